/* design/signed_int16_to_decimal_ascii_assert.svh */
// ----------------------------------------------------------------------------
// signed int16 to decimal ascii: assertion macros
// shared helpers for concurrent checks, clocked on aclk, idle in reset
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT16_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT16_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define SIDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sidc check failed");

// next-cycle implication
`define SIDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sidc check failed");

`endif

/* design/sidc_pkg.sv */
// ----------------------------------------------------------------------------
// sidc_pkg
// widths, character codes and the double-dabble step shared by the block
// ----------------------------------------------------------------------------
package sidc_pkg;

    localparam int VALUE_W    = 16;
    localparam int NUM_DIGITS = 5;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int NUM_CELLS  = VALUE_W;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_DIGITS - 1);

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } word_t;

    // one shift-and-add-3 step
    function automatic word_t dabble_step(word_t w);
        word_t            r;
        logic [BCD_W-1:0] adj;
        r   = w;
        adj = w.bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (adj[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
            end
        end
        {r.bcd, r.bin} = {adj[BCD_W-2:0], w.bin, 1'b0};
        return r;
    endfunction

endpackage

/* design/signed_int16_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// path: each input word passes through the 16 dabble cells, then the serializer
//   registers, before its first character; the serializer emits one character per
//   cycle while m_ready is high and loads the next word with the last character of
//   the current one; up to 16 words are in flight in the cell chain
// reset: aresetn synchronous, clears all valid flags, no words in flight
// ----------------------------------------------------------------------------
// signed_int16_to_decimal_ascii
// signed 16-bit value to ascii characters: optional minus sign, then five decimal digits
// ----------------------------------------------------------------------------
module signed_int16_to_decimal_ascii (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [sidc_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [sidc_pkg::CHAR_W-1:0]  m_char_code,
    output logic                         m_last_char
);
    import sidc_pkg::*;

    word_t              chain [0:NUM_CELLS];
    logic               advance;
    logic               load_ready;
    logic [VALUE_W-1:0] mag;

    // magnitude without overflow, -32768 gives 0x8000
    assign mag = s_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_value)) : VALUE_W'(s_value);

    assign chain[0] = '{valid: s_valid, neg: s_value[VALUE_W-1], bin: mag, bcd: '0};

    assign advance = !chain[NUM_CELLS].valid || load_ready;
    assign s_ready = advance;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        sidc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    sidc_ser u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .word_in     (chain[NUM_CELLS]),
        .load_ready  (load_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

endmodule

/* design/sidc_cell.sv */
// ----------------------------------------------------------------------------
// sidc_cell
// one double-dabble step on a word in flight, registered, stalls on hold
// ----------------------------------------------------------------------------
module sidc_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  sidc_pkg::word_t word_in,
    output sidc_pkg::word_t word_out
);
    import sidc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t data_reg;
    word_t data_next;

    always_comb begin
        valid_next = advance ? word_in.valid : valid_reg;
        data_next  = advance ? dabble_step(word_in) : data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_comb begin
        word_out       = data_reg;
        word_out.valid = valid_reg;
    end

endmodule

/* design/sidc_ser.sv */
// ----------------------------------------------------------------------------
// sidc_ser
// character serializer: optional minus sign, then the bcd digits msd first
// ----------------------------------------------------------------------------
module sidc_ser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sidc_pkg::word_t             word_in,
    output logic                        load_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sidc_pkg::CHAR_W-1:0] m_char_code,
    output logic                        m_last_char
);
    import sidc_pkg::*;

    logic             busy_reg,  busy_next;
    logic             sign_reg,  sign_next;
    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic [BCD_W-1:0] bcd_reg,   bcd_next;
    logic [3:0]       digit;
    logic             last;

    always_comb begin
        unique case (idx_reg)
            3'd0:    digit = bcd_reg[19:16];
            3'd1:    digit = bcd_reg[15:12];
            3'd2:    digit = bcd_reg[11:8];
            3'd3:    digit = bcd_reg[7:4];
            default: digit = bcd_reg[3:0];
        endcase
    end

    assign last        = !sign_reg && (idx_reg == LAST_IDX);
    assign m_valid     = busy_reg;
    assign m_last_char = last;
    assign m_char_code = sign_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});
    assign load_ready  = !busy_reg || (m_ready && last);

    always_comb begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        idx_next  = idx_reg;
        bcd_next  = bcd_reg;
        if (busy_reg && m_ready) begin
            if (sign_reg) begin
                sign_next = 1'b0;
            end else if (idx_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (word_in.valid && load_ready) begin
            busy_next = 1'b1;
            sign_next = word_in.neg;
            idx_next  = '0;
            bcd_next  = word_in.bcd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
    end

endmodule

/* design/sidc_check.sv */
// ----------------------------------------------------------------------------
// sidc_check
// port-level checks for the decimal ascii block, bound to the top level
// ----------------------------------------------------------------------------
`include "signed_int16_to_decimal_ascii_assert.svh"

module sidc_check (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [sidc_pkg::VALUE_W-1:0] s_value,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [sidc_pkg::CHAR_W-1:0]  m_char_code,
    input logic                         m_last_char
);
    import sidc_pkg::*;

    logic [CHAR_W:0] out_word;
    logic            is_minus;
    logic            is_digit;

    assign out_word = {m_char_code, m_last_char};
    assign is_minus = (m_char_code == CHAR_MINUS);
    assign is_digit = (m_char_code >= CHAR_ZERO) && (m_char_code <= CHAR_ZERO + 8'd9);

    // stalled input word holds
    `SIDC_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_value))

    // stalled output word holds
    `SIDC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_word))

    // only minus or digit codes, minus never closes a run
    `SIDC_ASSERT_NOW(a_code, m_valid, (is_minus && !m_last_char) || is_digit)

    // a minus sign is followed at once by a digit
    `SIDC_ASSERT_NEXT(a_after_minus, m_valid && m_ready && is_minus, m_valid && !is_minus)

    // a run does not break before its last word
    `SIDC_ASSERT_NEXT(a_run_gapless, m_valid && m_ready && !m_last_char, m_valid)

endmodule

bind signed_int16_to_decimal_ascii sidc_check u_check (.*);
